>>> rtl/fcct_pkg.sv
// Shared types and constants of the four-channel cascade timer.
package fcct_pkg;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    localparam logic [31:0] WRITABLE_BITS = 32'h00C7_FFFF;
    localparam logic [7:0]  CTL_WRITABLE  = 8'hC7;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    localparam int CTL_CASCADE_BIT = 2;
    localparam int CTL_IRQ_BIT     = 6;
    localparam int CTL_ENABLE_BIT  = 7;

    localparam logic [9:0] PRESCALE_MASK [4] = '{10'd0, 10'd63, 10'd255, 10'd1023};

    typedef struct packed {
        logic        tick;
        logic        write;
        logic [31:0] data;
        logic [31:0] mask;
        logic [9:0]  cycle;
    } chan_cmd_t;

    typedef struct packed {
        logic [15:0] count;
        logic [7:0]  ctl;
        logic        ovf;
        logic        irq;
    } chan_stat_t;

endpackage

>>> rtl/fcct_channel.sv
// One timer channel: reload, counter and control byte with prescale and cascade increment.
module fcct_channel
    import fcct_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  chan_cmd_t  cmd,
    input  logic       wr_sel,
    input  logic       cascade_allow,
    input  logic       carry_in,
    output chan_stat_t stat
);

    logic [15:0] reload_reg, reload_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  ctl_reg, ctl_next;
    logic        fire;
    logic        inc;
    logic        ovf;
    logic [15:0] lo_m;
    logic [7:0]  hi_m;
    logic [15:0] wr_reload;
    logic [7:0]  wr_ctl;

    assign fire = ((cmd.cycle & PRESCALE_MASK[ctl_reg[1:0]]) == 10'd0);
    assign inc  = cmd.tick && ctl_reg[CTL_ENABLE_BIT]
                  && (ctl_reg[CTL_CASCADE_BIT] ? carry_in : fire);
    assign ovf  = inc && (count_reg == COUNT_MAX);

    assign lo_m = cmd.mask[15:0];
    assign hi_m = cmd.mask[23:16];

    always_comb begin
        wr_reload = (cmd.data[15:0] & lo_m) | (reload_reg & ~lo_m);
        wr_ctl    = ((cmd.data[23:16] & hi_m) | (ctl_reg & ~hi_m)) & CTL_WRITABLE;
        if (!cascade_allow) begin
            wr_ctl[CTL_CASCADE_BIT] = 1'b0;
        end
        reload_next = reload_reg;
        ctl_next    = ctl_reg;
        count_next  = count_reg;
        if (cmd.write && wr_sel) begin
            reload_next = wr_reload;
            ctl_next    = wr_ctl;
            if (wr_ctl[CTL_ENABLE_BIT] && !ctl_reg[CTL_ENABLE_BIT]) begin
                count_next = wr_reload;
            end
        end else if (inc) begin
            count_next = ovf ? reload_reg : count_reg + 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reload_reg <= '0;
            count_reg  <= '0;
            ctl_reg    <= '0;
        end else begin
            reload_reg <= reload_next;
            count_reg  <= count_next;
            ctl_reg    <= ctl_next;
        end
    end

    assign stat.count = count_reg;
    assign stat.ctl   = ctl_reg;
    assign stat.ovf   = ovf;
    assign stat.irq   = ovf && ctl_reg[CTL_IRQ_BIT];

endmodule

>>> rtl/four_channel_cascade_timer_top.sv
// Top level of the cascade timer: request register, channel array and result register.
// Takes one request per clock while s_ready is high (tick, control read or control write)
// and returns one result per request: the request is captured in an input register, the
// channel counters, prescale compare and cascade ripple across all channels settle from it
// and land in the result register once it is free, which is also when the channel state
// updates. A tick advances the 10-bit cycle counter and counts each enabled channel whose
// divider (1, 64, 256 or 1024) divides the new count, or whose lower neighbor overflowed in
// cascade mode; irq_pulse flags overflows with irq enabled. A read returns the control byte in bits
// 16-23 and the live counter; a write updates the writable control bits 0x00C7FFFF under
// the bit mask and loads the counter on a rising enable. s_ready drops only while both
// the input and result registers are full and m_ready is low.
module four_channel_cascade_timer_top
    import fcct_pkg::*;
#(
    parameter int CHANNELS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [1:0]  s_channel,
    input  logic [31:0] s_write_data,
    input  logic [31:0] s_write_mask,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data,
    output logic [3:0]  m_irq_pulse
);

    localparam int         IDX_W    = $clog2(CHANNELS);
    localparam logic [2:0] CH_LIMIT = 3'(CHANNELS);

    logic        in_valid_reg;
    action_t     action_reg;
    logic [1:0]  channel_reg;
    logic [31:0] data_reg;
    logic [31:0] mask_reg;
    logic        out_valid_reg;
    logic [31:0] read_data_reg, read_data_next;
    logic [3:0]  irq_reg, irq_next;
    logic [9:0]  cycle_reg, cycle_next;
    logic        advance;
    logic        ch_ok;
    logic        do_tick;
    chan_cmd_t   cmd;
    chan_stat_t  stat [CHANNELS];
    logic [CHANNELS-1:0] irq_vec;
    logic [CHANNELS-1:0] wr_sel;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign ch_ok   = ({1'b0, channel_reg} < CH_LIMIT);
    assign do_tick = advance && (action_reg == ACT_TICK);

    assign cycle_next = cycle_reg + 10'd1;

    assign cmd.tick  = do_tick;
    assign cmd.write = advance && (action_reg == ACT_WRITE) && ch_ok;
    assign cmd.data  = data_reg;
    assign cmd.mask  = mask_reg & WRITABLE_BITS;
    assign cmd.cycle = cycle_next;

    genvar gi;
    generate
        for (gi = 0; gi < CHANNELS; gi++) begin : g_chan
            assign wr_sel[gi]  = (channel_reg[IDX_W-1:0] == IDX_W'(gi));
            assign irq_vec[gi] = stat[gi].irq;
            if (gi == 0) begin : g_first
                fcct_channel u_chan (
                    .aclk          (aclk),
                    .aresetn       (aresetn),
                    .cmd           (cmd),
                    .wr_sel        (wr_sel[gi]),
                    .cascade_allow (1'b0),
                    .carry_in      (1'b0),
                    .stat          (stat[gi])
                );
            end else begin : g_next
                fcct_channel u_chan (
                    .aclk          (aclk),
                    .aresetn       (aresetn),
                    .cmd           (cmd),
                    .wr_sel        (wr_sel[gi]),
                    .cascade_allow (1'b1),
                    .carry_in      (stat[gi-1].ovf),
                    .stat          (stat[gi])
                );
            end
        end
    endgenerate

    always_comb begin
        read_data_next = '0;
        irq_next       = '0;
        case (action_reg)
            ACT_TICK: begin
                irq_next[CHANNELS-1:0] = irq_vec;
            end
            ACT_READ: begin
                if (ch_ok) begin
                    read_data_next = {8'd0, stat[channel_reg[IDX_W-1:0]].ctl,
                                      stat[channel_reg[IDX_W-1:0]].count};
                end
            end
            default: begin
                read_data_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cycle_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (do_tick) begin
                cycle_reg <= cycle_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            action_reg  <= action_t'(s_action);
            channel_reg <= s_channel;
            data_reg    <= s_write_data;
            mask_reg    <= s_write_mask;
        end
        if (advance) begin
            read_data_reg <= read_data_next;
            irq_reg       <= irq_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_read_data = read_data_reg;
    assign m_irq_pulse = irq_reg;

    a_irq_only_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (action_reg != ACT_TICK)) |=> (irq_reg == 4'd0))
        else $error("irq pulse on a non-tick request");

    a_data_only_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (action_reg != ACT_READ)) |=> (read_data_reg == 32'd0))
        else $error("read data on a non-read request");

    a_cycle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !do_tick |=> $stable(cycle_reg))
        else $error("cycle count moved without a tick");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("request taken while both stages are stalled");

endmodule
